// ----- src/ppq_pkg.sv -----
// shared types and constants of the preemptive priority ready queue
package ppq_pkg;

    localparam int ID_W   = 4;
    localparam int PRIO_W = 8;

    localparam logic [1:0] CMD_REGISTER = 2'd0;
    localparam logic [1:0] CMD_ENQUEUE  = 2'd1;
    localparam logic [1:0] CMD_DISPATCH = 2'd2;

    localparam logic [PRIO_W-1:0] AGING_RESET = 8'h0A;

    typedef struct packed {
        logic [1:0]        command;
        logic [ID_W-1:0]   task_id;
        logic [PRIO_W-1:0] priority_req;
        logic              protection_active;
    } sched_req_t;

    typedef struct packed {
        logic [ID_W-1:0]   next_task;
        logic              preempted;
        logic              dropped;
        logic              switch_request;
        logic [PRIO_W-1:0] running_priority;
    } sched_res_t;

    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } ready_ent_t;

    typedef struct packed {
        logic            valid;
        logic [ID_W-1:0] id;
    } fifo_ent_t;

    typedef struct packed {
        logic              insert;
        logic              pop;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } sort_op_t;

    typedef struct packed {
        logic            push;
        logic            pop;
        logic [ID_W-1:0] id;
    } fifo_op_t;

    typedef struct packed {
        logic              en;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] base;
        logic [PRIO_W-1:0] cur;
    } table_wr_t;

endpackage

// ----- src/ppq_task_table.sv -----
// task priority table: base and current priority per task, one read and one write port
module ppq_task_table #(
    parameter int TASK_COUNT = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [ppq_pkg::ID_W-1:0]    rd_id,
    input  ppq_pkg::table_wr_t          wr,
    output logic [ppq_pkg::PRIO_W-1:0]  rd_base,
    output logic [ppq_pkg::PRIO_W-1:0]  rd_cur
);

    localparam int AW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
    localparam int EW = AW + ppq_pkg::ID_W;

    logic [ppq_pkg::PRIO_W-1:0] base_mem [TASK_COUNT];
    logic [ppq_pkg::PRIO_W-1:0] cur_mem  [TASK_COUNT];
    logic [TASK_COUNT-1:0]      valid_reg;
    logic [ppq_pkg::PRIO_W-1:0] rd_base_reg;
    logic [ppq_pkg::PRIO_W-1:0] rd_cur_reg;

    logic [EW-1:0] rd_ext;
    logic [EW-1:0] wr_ext;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          rd_hit;
    logic          wr_hit;

    assign rd_ext  = EW'(rd_id);
    assign wr_ext  = EW'(wr.id);
    assign rd_addr = rd_ext[AW-1:0];
    assign wr_addr = wr_ext[AW-1:0];
    assign rd_hit  = (rd_ext < EW'(TASK_COUNT));
    assign wr_hit  = wr.en && (wr_ext < EW'(TASK_COUNT));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_hit) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_hit) begin
            base_mem[wr_addr] <= wr.base;
            cur_mem[wr_addr]  <= wr.cur;
        end
        if (rd_hit && valid_reg[rd_addr]) begin
            rd_base_reg <= base_mem[rd_addr];
            rd_cur_reg  <= cur_mem[rd_addr];
        end else begin
            rd_base_reg <= '0;
            rd_cur_reg  <= '0;
        end
    end

    assign rd_base = rd_base_reg;
    assign rd_cur  = rd_cur_reg;

endmodule

// ----- src/ppq_sort_cell.sv -----
// one cell of the sorted ready queue: holds an entry, shifts down on insert and up on pop
module ppq_sort_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  ppq_pkg::sort_op_t   op,
    input  logic                prev_stay,
    input  ppq_pkg::ready_ent_t prev_ent,
    input  ppq_pkg::ready_ent_t next_ent,
    output ppq_pkg::ready_ent_t ent,
    output logic                stay
);

    logic                       valid_reg;
    logic [ppq_pkg::ID_W-1:0]   id_reg;
    logic [ppq_pkg::PRIO_W-1:0] prio_reg;

    // entry keeps its place when it ranks at or above the new one
    assign stay = valid_reg && (prio_reg >= op.prio);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (op.insert && !stay) begin
            valid_reg <= prev_stay ? 1'b1 : prev_ent.valid;
        end else if (op.pop) begin
            valid_reg <= next_ent.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (op.insert && !stay) begin
            if (prev_stay) begin
                id_reg   <= op.id;
                prio_reg <= op.prio;
            end else begin
                id_reg   <= prev_ent.id;
                prio_reg <= prev_ent.prio;
            end
        end else if (op.pop) begin
            id_reg   <= next_ent.id;
            prio_reg <= next_ent.prio;
        end
    end

    assign ent.valid = valid_reg;
    assign ent.id    = id_reg;
    assign ent.prio  = prio_reg;

endmodule

// ----- src/ppq_fifo_cell.sv -----
// one cell of the preempted-task fifo: fills at the tail, shifts up on pop
module ppq_fifo_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  ppq_pkg::fifo_op_t  op,
    input  logic               prev_valid,
    input  ppq_pkg::fifo_ent_t next_ent,
    output ppq_pkg::fifo_ent_t ent
);

    logic                     valid_reg;
    logic [ppq_pkg::ID_W-1:0] id_reg;
    logic                     load;

    assign load = op.push && !valid_reg && prev_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (op.pop) begin
            valid_reg <= next_ent.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            id_reg <= op.id;
        end else if (op.pop) begin
            id_reg <= next_ent.id;
        end
    end

    assign ent.valid = valid_reg;
    assign ent.id    = id_reg;

endmodule

// ----- src/preemptive_priority_ready_queue.sv -----
// top level of the preemptive priority ready queue scheduler
//
// channel  | dir | handshake          | payload
// ---------+-----+--------------------+-------------------------------
// request  | in  | s_valid / s_ready  | s_req  (ppq_pkg::sched_req_t)
// result   | out | m_valid / m_ready  | m_res  (ppq_pkg::sched_res_t)
// config   | in  | cfg_wr_en          | cfg_wr_data (aging threshold)
//
// each request passes from accept through result load: accept with task
// table read, execute, fifo head table read, result load; the next request
// is accepted only after the result of the last one has loaded
// the task table is read at accept, written in execute, and read for the fifo head
// from then until the result loads
// aresetn is synchronous and clears both queues, the running task and the table
// a result held by m_ready low stalls only the result load step of the next request
module preemptive_priority_ready_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TASK_COUNT  = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  ppq_pkg::sched_req_t        s_req,
    output logic                       m_valid,
    input  logic                       m_ready,
    output ppq_pkg::sched_res_t        m_res,
    input  logic                       cfg_wr_en,
    input  logic [ppq_pkg::PRIO_W-1:0] cfg_wr_data
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_TEST = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    ppq_pkg::sched_req_t        req_reg;
    logic [ppq_pkg::ID_W-1:0]   addr_reg;
    logic [ppq_pkg::PRIO_W-1:0] thr_reg;
    logic [ppq_pkg::ID_W-1:0]   run_task_reg;
    logic [ppq_pkg::ID_W-1:0]   run_task_next;
    logic [ppq_pkg::PRIO_W-1:0] run_prio_reg;
    logic [ppq_pkg::PRIO_W-1:0] run_prio_next;
    logic [ppq_pkg::ID_W-1:0]   next_task_reg;
    logic [ppq_pkg::ID_W-1:0]   next_task_next;
    logic                       pre_reg;
    logic                       pre_next;
    logic                       drop_reg;
    logic                       drop_next;
    logic                       m_valid_reg;
    ppq_pkg::sched_res_t        m_res_reg;

    ppq_pkg::ready_ent_t ready_ent [QUEUE_DEPTH];
    logic                ready_stay [QUEUE_DEPTH];
    ppq_pkg::fifo_ent_t  fifo_ent [QUEUE_DEPTH];
    ppq_pkg::sort_op_t   sort_op;
    ppq_pkg::fifo_op_t   fifo_op;
    ppq_pkg::table_wr_t  tbl_wr;

    logic [ppq_pkg::ID_W-1:0]   accept_id;
    logic [ppq_pkg::ID_W-1:0]   rd_id;
    logic [ppq_pkg::PRIO_W-1:0] rd_base;
    logic [ppq_pkg::PRIO_W-1:0] rd_cur;
    logic [ppq_pkg::PRIO_W-1:0] aged;
    logic                       preempt;
    logic                       accept;
    logic                       load;
    logic                       switch_req;

    logic [QUEUE_DEPTH-1:0] ready_vld;
    logic [QUEUE_DEPTH-1:0] fifo_vld;
    logic [QUEUE_DEPTH-2:0] order_ok;

    // queue cells
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cells
        ppq_pkg::ready_ent_t prev_r;
        ppq_pkg::ready_ent_t next_r;
        ppq_pkg::fifo_ent_t  next_f;
        logic                prev_s;
        logic                prev_v;

        if (i == 0) begin : g_first
            assign prev_r = '0;
            assign prev_s = 1'b1;
            assign prev_v = 1'b1;
        end else begin : g_mid
            assign prev_r = ready_ent[i-1];
            assign prev_s = ready_stay[i-1];
            assign prev_v = fifo_ent[i-1].valid;
        end

        if (i == QUEUE_DEPTH - 1) begin : g_last
            assign next_r = '0;
            assign next_f = '0;
        end else begin : g_inner
            assign next_r = ready_ent[i+1];
            assign next_f = fifo_ent[i+1];
        end

        ppq_sort_cell u_sort (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .op        (sort_op),
            .prev_stay (prev_s),
            .prev_ent  (prev_r),
            .next_ent  (next_r),
            .ent       (ready_ent[i]),
            .stay      (ready_stay[i])
        );

        ppq_fifo_cell u_fifo (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .op         (fifo_op),
            .prev_valid (prev_v),
            .next_ent   (next_f),
            .ent        (fifo_ent[i])
        );

        assign ready_vld[i] = ready_ent[i].valid;
        assign fifo_vld[i]  = fifo_ent[i].valid;

        if (i < QUEUE_DEPTH - 1) begin : g_order
            assign order_ok[i] = !ready_ent[i+1].valid ||
                                 (ready_ent[i].prio >= ready_ent[i+1].prio);
        end
    end

    ppq_task_table #(
        .TASK_COUNT (TASK_COUNT)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_id   (rd_id),
        .wr      (tbl_wr),
        .rd_base (rd_base),
        .rd_cur  (rd_cur)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign load    = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    // table address: dispatch reads the task it will pick
    always_comb begin
        if (s_req.command == ppq_pkg::CMD_DISPATCH) begin
            if (fifo_ent[0].valid) begin
                accept_id = fifo_ent[0].id;
            end else if (ready_ent[0].valid) begin
                accept_id = ready_ent[0].id;
            end else begin
                accept_id = '0;
            end
        end else begin
            accept_id = s_req.task_id;
        end
    end

    // fifo head stays addressed while the result waits
    assign rd_id = ((state_reg == ST_TEST) || (state_reg == ST_DONE)) ? fifo_ent[0].id :
                   accept_id;

    assign preempt = (req_reg.priority_req > run_prio_reg) && (run_task_reg != '0) &&
                     !req_reg.protection_active;

    always_comb begin
        aged = rd_cur;
        if ((rd_cur < thr_reg) && (rd_cur != '0)) begin
            aged = rd_cur - 8'd1;
        end
        if (aged == '0) begin
            aged = rd_base;
        end
    end

    always_comb begin
        sort_op        = '0;
        fifo_op        = '0;
        tbl_wr         = '0;
        run_task_next  = run_task_reg;
        run_prio_next  = run_prio_reg;
        next_task_next = '0;
        pre_next       = 1'b0;
        drop_next      = 1'b0;
        if (state_reg == ST_EXEC) begin
            unique case (req_reg.command)
                ppq_pkg::CMD_REGISTER: begin
                    tbl_wr.en   = 1'b1;
                    tbl_wr.id   = addr_reg;
                    tbl_wr.base = req_reg.priority_req;
                    tbl_wr.cur  = req_reg.priority_req;
                end
                ppq_pkg::CMD_ENQUEUE: begin
                    if (preempt) begin
                        if (fifo_ent[QUEUE_DEPTH-1].valid) begin
                            drop_next = 1'b1;
                        end else begin
                            fifo_op.push = 1'b1;
                            fifo_op.id   = run_task_reg;
                        end
                        run_task_next  = req_reg.task_id;
                        run_prio_next  = rd_cur;
                        next_task_next = req_reg.task_id;
                        pre_next       = 1'b1;
                    end else if (ready_ent[QUEUE_DEPTH-1].valid) begin
                        drop_next = 1'b1;
                    end else begin
                        sort_op.insert = 1'b1;
                        sort_op.id     = req_reg.task_id;
                        sort_op.prio   = req_reg.priority_req;
                    end
                end
                ppq_pkg::CMD_DISPATCH: begin
                    if (fifo_ent[0].valid) begin
                        fifo_op.pop   = 1'b1;
                        run_prio_next = rd_cur;
                    end else if (ready_ent[0].valid) begin
                        sort_op.pop   = 1'b1;
                        run_prio_next = ready_ent[0].prio;
                    end else begin
                        run_prio_next = '0;
                    end
                    run_task_next  = addr_reg;
                    next_task_next = addr_reg;
                    tbl_wr.en      = 1'b1;
                    tbl_wr.id      = addr_reg;
                    tbl_wr.base    = rd_base;
                    tbl_wr.cur     = aged;
                end
                default: begin
                end
            endcase
        end
    end

    assign switch_req = (ready_ent[0].valid && (run_prio_reg < ready_ent[0].prio)) ||
                        (fifo_ent[0].valid && (run_prio_reg < rd_cur));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: state_next = ST_TEST;
            ST_TEST: state_next = ST_DONE;
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            thr_reg      <= ppq_pkg::AGING_RESET;
            run_task_reg <= '0;
            run_prio_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            run_task_reg <= run_task_next;
            run_prio_reg <= run_prio_next;
            if (cfg_wr_en) begin
                thr_reg <= cfg_wr_data;
            end
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg  <= s_req;
            addr_reg <= accept_id;
        end
        if (state_reg == ST_EXEC) begin
            next_task_reg <= next_task_next;
            pre_reg       <= pre_next;
            drop_reg      <= drop_next;
        end
        if (load) begin
            m_res_reg.next_task        <= next_task_reg;
            m_res_reg.preempted        <= pre_reg;
            m_res_reg.dropped          <= drop_reg;
            m_res_reg.switch_request   <= switch_req;
            m_res_reg.running_priority <= run_prio_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;

    // ready queue entries stay packed at the head
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((ready_vld & (ready_vld + QUEUE_DEPTH'(1))) == '0))
        else $error("ready queue has a gap");

    // preempted fifo entries stay packed at the head
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((fifo_vld & (fifo_vld + QUEUE_DEPTH'(1))) == '0))
        else $error("preempted fifo has a gap");

    // ready queue stays in descending priority order
    assert property (@(posedge aclk) disable iff (!aresetn)
        (&order_ok))
        else $error("ready queue out of order");

    // the execute step is always followed by the fifo head read step
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC) |=> (state_reg == ST_TEST))
        else $error("sequencer skipped the fifo head read");

endmodule
